[rtl/core/assert_macros.svh]
// assertion macros shared by the classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FSC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FSC_ASSERT(lbl, prop, msg)
`define FSC_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

[rtl/core/fsc_pkg.sv]
// types and constants of the flow signature classifier
package fsc_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_MARKER_PORT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STAGE_LIMIT = 2'd1;

  localparam logic [15:0] MARKER_PORT_RST = 16'd12345;
  localparam logic [3:0]  STAGE_LIMIT_RST = 4'd8;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_DET  = 2'd1,
    VERDICT_EXC  = 2'd2
  } verdict_t;

  localparam logic [3:0] RULE_NONE     = 4'd0;
  localparam logic [3:0] RULE_PORT     = 4'd1;
  localparam logic [3:0] RULE_UDP_LEN  = 4'd2;
  localparam logic [3:0] RULE_UDP_SIG0 = 4'd3;
  localparam logic [3:0] RULE_UDP_SIG1 = 4'd4;
  localparam logic [3:0] RULE_UDP_SIG2 = 4'd5;
  localparam logic [3:0] RULE_UDP_SIG3 = 4'd6;
  localparam logic [3:0] RULE_UDP_SIG4 = 4'd7;
  localparam logic [3:0] RULE_UDP_SIG5 = 4'd8;
  localparam logic [3:0] RULE_TCP_LEN  = 4'd9;
  localparam logic [3:0] RULE_TCP_SIG  = 4'd10;

  typedef struct packed {
    logic        mode;
    logic        new_flow;
    logic [15:0] source_port;
    logic [15:0] body_len;
    logic [63:0] head_bytes_low;
    logic [63:0] head_bytes_mid;
    logic [31:0] head_bytes_top;
  } item_t;

  typedef struct packed {
    logic [15:0] marker_port;
    logic [3:0]  udp_stage_limit;
  } fsc_cfg_t;

  typedef struct packed {
    logic [3:0] packet_stage;
    logic [3:0] match_count;
    verdict_t   held_verdict;
  } fsc_state_t;

endpackage

[rtl/core/fsc_if.sv]
// channel interfaces: packet items, results and register writes
interface fsc_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        new_flow;
  logic [15:0] source_port;
  logic [15:0] body_len;
  logic [63:0] head_bytes_low;
  logic [63:0] head_bytes_mid;
  logic [31:0] head_bytes_top;

  modport source (output valid, mode, new_flow, source_port, body_len,
                  head_bytes_low, head_bytes_mid, head_bytes_top, input ready);
  modport sink   (input valid, mode, new_flow, source_port, body_len,
                  head_bytes_low, head_bytes_mid, head_bytes_top, output ready);
endinterface

interface fsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [3:0] matched_rule;

  modport source (output valid, verdict, matched_rule, input ready);
  modport sink   (input valid, verdict, matched_rule, output ready);
endinterface

interface fsc_cfg_if import fsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/core/fsc_cfg_regs.sv]
// configuration registers: marker port and udp stage limit
module fsc_cfg_regs import fsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fsc_cfg_if.sink    cfg_chan,
  output fsc_cfg_t   cfg
);

  fsc_cfg_t cfg_r;
  fsc_cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.addr)
        CFG_MARKER_PORT: cfg_nxt.marker_port = cfg_chan.data;
        CFG_STAGE_LIMIT: cfg_nxt.udp_stage_limit = cfg_chan.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.marker_port     <= MARKER_PORT_RST;
      cfg_r.udp_stage_limit <= STAGE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/fsc_classify.sv]
// per-packet classification and flow state update
module fsc_classify import fsc_pkg::*; (
  input  item_t      item,
  input  fsc_cfg_t   cfg,
  input  fsc_state_t state,
  output fsc_state_t state_nxt,
  output logic [1:0] verdict,
  output logic [3:0] rule
);

  function automatic logic [3:0] sat_inc(input logic [3:0] x);
    sat_inc = (x == 4'hf) ? 4'hf : x + 4'd1;
  endfunction

  logic [159:0] head;
  assign head = {item.head_bytes_low, item.head_bytes_mid, item.head_bytes_top};

  // byte pairs, big-endian, named by their first byte
  logic [15:0] pr0, pr2, pr3, pr4, pr5, pr8, pr13, pr18;
  logic [7:0]  b2;
  assign pr0  = head[159 -: 16];
  assign pr2  = head[143 -: 16];
  assign pr3  = head[135 -: 16];
  assign pr4  = head[127 -: 16];
  assign pr5  = head[119 -: 16];
  assign pr8  = head[95  -: 16];
  assign pr13 = head[55  -: 16];
  assign pr18 = head[15  -: 16];
  assign b2   = head[143 -: 8];

  logic [3:0] sig_rule;
  always_comb begin
    sig_rule = RULE_NONE;
    if (pr0 == 16'h0100 && pr3 == 16'h2a6e && pr8 == 16'h1327)
      sig_rule = RULE_UDP_SIG0;
    else if (pr0 == 16'h4100 && pr13 == 16'h0800 && pr18 == 16'h0000)
      sig_rule = RULE_UDP_SIG1;
    else if (pr0 == 16'h4300 && pr4 == 16'hff01)
      sig_rule = RULE_UDP_SIG2;
    else if (item.head_bytes_low == 64'h3e000000fc100000)
      sig_rule = RULE_UDP_SIG3;
    else if (pr0 == 16'h6431 && b2 == 8'h3a)
      sig_rule = RULE_UDP_SIG4;
    else if (pr0 == 16'h4200 && pr2 == 16'h0000 && pr5 == 16'h1000)
      sig_rule = RULE_UDP_SIG5;
  end

  logic [3:0] stage0;
  logic [3:0] count0;
  verdict_t   held0;
  logic [3:0] stage1;
  logic       exc;
  logic       tcp_hit;
  logic [15:0] len;

  always_comb begin
    stage0 = item.new_flow ? 4'd0 : state.packet_stage;
    count0 = item.new_flow ? 4'd0 : state.match_count;
    held0  = item.new_flow ? VERDICT_NONE : state.held_verdict;
    stage1 = sat_inc(stage0);
    len    = item.body_len;
    exc    = 1'b0;
    rule   = RULE_NONE;
    tcp_hit = 1'b0;
    state_nxt.packet_stage = stage0;
    state_nxt.match_count  = count0;
    state_nxt.held_verdict = held0;

    if (held0 == VERDICT_NONE) begin
      if (item.mode) begin
        if (item.source_port == cfg.marker_port) begin
          rule = RULE_PORT;
        end else begin
          state_nxt.packet_stage = stage1;
          if (stage1 <= cfg.udp_stage_limit && len >= 16'd40 && len < 16'd50) begin
            state_nxt.match_count = sat_inc(count0);
          end else if ({1'b0, stage1} == {1'b0, count0} + 5'd1 && stage1 >= 4'd3 &&
                       len >= 16'd220) begin
            rule = RULE_UDP_LEN;
          end
          if (rule == RULE_NONE) begin
            if (len > 16'd16) rule = sig_rule;
            if (rule == RULE_NONE && stage1 > cfg.udp_stage_limit) exc = 1'b1;
          end
        end
      end else begin
        state_nxt.packet_stage = stage1;
        case (count0)
          4'd0:    tcp_hit = (len == 16'd185);
          4'd1:    tcp_hit = (len >= 16'd9 && len <= 16'd12);
          4'd2:    tcp_hit = (len >= 16'd18 && len <= 16'd21);
          4'd3:    tcp_hit = (len == 16'd92);
          4'd4:    tcp_hit = (len >= 16'd109 && len <= 16'd111);
          4'd5:    tcp_hit = (len == 16'd21);
          default: tcp_hit = 1'b1;
        endcase
        // counts above five only come from mixed transports: sequence idle
        if (count0 <= 4'd5) begin
          if (tcp_hit) begin
            state_nxt.match_count = count0 + 4'd1;
            if (count0 == 4'd5) rule = RULE_TCP_LEN;
          end else begin
            exc = 1'b1;
          end
        end
        if (rule == RULE_NONE && pr0 == 16'h0400) rule = RULE_TCP_SIG;
      end
      // detection wins over exclusion
      if (rule != RULE_NONE) state_nxt.held_verdict = VERDICT_DET;
      else if (exc) state_nxt.held_verdict = VERDICT_EXC;
    end
    verdict = state_nxt.held_verdict;
  end

endmodule

[rtl/core/flow_signature_classifier.sv]
// top level of the flow signature classifier
// Takes one packet per clock when unstalled and returns one result per packet in order.
// A packet is captured in an input register, classified against the flow state, and
// the verdict lands in the result register. The sustained rate when unstalled is one
// packet per cycle; it is set by the flow state loop, which reads and rewrites packet
// stage, match count and held verdict for each packet. A stalled result register
// holds the input register, and the input side keeps accepting while the result
// register is free or being drained in the same cycle. The user must write registers
// through the configuration channel only while no packet is in flight; not enforced.
`include "assert_macros.svh"
module flow_signature_classifier import fsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  fsc_item_if.sink      in_chan,
  fsc_result_if.source  out_chan,
  fsc_cfg_if.sink       cfg_chan
);

  fsc_cfg_t   cfg;
  item_t      item_r, item_nxt;
  logic       item_valid_r, item_valid_nxt;
  fsc_state_t state_r, state_nxt, state_upd;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] verdict_r, verdict_nxt, verdict_c;
  logic [3:0] rule_r, rule_nxt, rule_c;
  logic       advance;
  logic       in_xfer;
  logic       held_keep;
  logic       rule_shown;

  fsc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  fsc_classify u_classify (
    .item      (item_r),
    .cfg       (cfg),
    .state     (state_r),
    .state_nxt (state_upd),
    .verdict   (verdict_c),
    .rule      (rule_c)
  );

  assign advance       = item_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !item_valid_r || advance;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.verdict      = verdict_r;
  assign out_chan.matched_rule = rule_r;

  always_comb begin
    item_nxt       = item_r;
    item_valid_nxt = item_valid_r;
    if (in_xfer) begin
      item_valid_nxt          = 1'b1;
      item_nxt.mode           = in_chan.mode;
      item_nxt.new_flow       = in_chan.new_flow;
      item_nxt.source_port    = in_chan.source_port;
      item_nxt.body_len       = in_chan.body_len;
      item_nxt.head_bytes_low = in_chan.head_bytes_low;
      item_nxt.head_bytes_mid = in_chan.head_bytes_mid;
      item_nxt.head_bytes_top = in_chan.head_bytes_top;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end

    state_nxt     = advance ? state_upd : state_r;
    verdict_nxt   = advance ? verdict_c : verdict_r;
    rule_nxt      = advance ? rule_c : rule_r;
    out_valid_nxt = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r          <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.packet_stage  <= 4'd0;
      state_r.match_count   <= 4'd0;
      state_r.held_verdict  <= VERDICT_NONE;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      state_r      <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    verdict_r <= verdict_nxt;
    rule_r    <= rule_nxt;
  end

  assign held_keep  = advance && !item_r.new_flow && state_r.held_verdict != VERDICT_NONE;
  assign rule_shown = out_valid_r && rule_r != RULE_NONE;

  `FSC_ASSERT_ANY(a_rst_clears_out, !rst_n |=> !out_valid_r, "result valid after reset")
  `FSC_ASSERT(a_state_frozen, !advance |=> state_r == $past(state_r), "state moved while idle")
  `FSC_ASSERT(a_verdict_held, held_keep |=> state_r == $past(state_r), "held verdict not kept")
  `FSC_ASSERT(a_rule_implies_det, rule_shown |-> verdict_r == VERDICT_DET, "rule without detection")
  `FSC_ASSERT(a_ready_when_free, !out_valid_r |-> in_chan.ready, "input held with empty output")

endmodule
